// ===== hw/rtl/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and constants of the trial division prime filter
// Holds the field widths, the derived divisor and square widths, the
// sequencer state type and the structs passed between the block's modules.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // Field widths on the streaming ports.
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 8;

  // Bits of the input value that take part in the test.
  localparam int VALUE_BITS = 16;
  localparam int VB         = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  // Trial divisors never pass sqrt(2^VB) + 2; the running square of the
  // divisor stays below 2^(VB+2).
  localparam int DIV_BITS = (VB + 1) / 2 + 2;
  localparam int SQ_BITS  = VB + 2;
  localparam int STEP_W   = $clog2(VB + 1);

  // Saturation point of the running prime count.
  localparam logic [COUNT_W-1:0] MAX_LEN = COUNT_W'(128);

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Request to the serial remainder unit.
  typedef struct packed {
    logic                start;
    logic [VB-1:0]       dividend;
    logic [DIV_BITS-1:0] divisor;
  } rem_req_t;

  // Status from the serial remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_rsp_t;

  // One result item as held by the output stage.
  typedef struct packed {
    logic [VALUE_W-1:0] prime_value;
    logic               keep;
    logic [COUNT_W-1:0] prime_count;
    logic               run_end;
  } out_item_t;

endpackage

// ===== hw/rtl/ptd_rem_unit.sv =====
// ----------------------------------------------------------------------------
// ptd_rem_unit: bit-serial remainder unit
// Restoring division that shifts the dividend in one bit per cycle, most
// significant bit first, and keeps only the partial remainder.
// ----------------------------------------------------------------------------
module ptd_rem_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  ptd_pkg::rem_req_t req,
  output ptd_pkg::rem_rsp_t rsp
);
  import ptd_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [VB-1:0]       shift_r, shift_nxt;
  logic [DIV_BITS-1:0] rem_r, rem_nxt;
  logic [DIV_BITS-1:0] dsr_r, dsr_nxt;
  logic [DIV_BITS:0]   trial;

  // One restoring step: bring in the next dividend bit and subtract if it fits.
  assign trial = {rem_r, shift_r[VB-1]};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    dsr_nxt   = dsr_r;
    if (req.start && !busy_r) begin
      busy_nxt  = 1'b1;
      step_nxt  = STEP_W'(VB);
      shift_nxt = req.dividend;
      rem_nxt   = '0;
      dsr_nxt   = req.divisor;
    end else if (busy_r) begin
      shift_nxt = shift_r << 1;
      step_nxt  = step_r - STEP_W'(1);
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIV_BITS'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[DIV_BITS-1:0];
      end
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    dsr_r   <= dsr_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.zero = (rem_r == '0);

endmodule

// ===== hw/rtl/ptd_out_stage.sv =====
// ----------------------------------------------------------------------------
// ptd_out_stage: result register
// Holds one result item toward the receiver and frees the sequencer while
// the item waits to be taken.
// ----------------------------------------------------------------------------
module ptd_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ptd_pkg::out_item_t item,
  output logic               slot_free,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,  // [15:0] prime_value, [23:16] prime_count
  output logic               out_tuser,  // [0] keep
  output logic               out_tlast   // run_end
);
  import ptd_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  // The slot can take a new item when it is empty or drains this cycle.
  assign slot_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {item_r.prime_count, item_r.prime_value};
  assign out_tuser  = item_r.keep;
  assign out_tlast  = item_r.run_end;

endmodule

// ===== hw/rtl/prime_filter_trial_division_core.sv =====
// ----------------------------------------------------------------------------
// prime_filter_trial_division_core: trial division prime filter
// Tests each incoming value for primality and forwards primes, plus one
// result for the last item of every run, with a running prime count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_tdata carries the value, in_tlast marks the last item
//   of a run. One item is taken at a time; in_tready is high only while the
//   block has no item in work.
//   Result channel: out_tdata carries the value and the running prime count,
//   out_tuser the keep flag, out_tlast the run-end flag. A non-prime item
//   that is not the last of its run gives no result.
//   Values below 4 and even values go from the idle state straight to the
//   done state, which loads any result into the output register once it
//   is free and then returns to idle. Odd values go through trial
//   divisors 3, 5, 7, ... up to the square root; each divisor passes the
//   check state, which starts the bit-serial remainder unit, and the divide
//   state, which waits for the unit to finish. A new item is taken only
//   after the block is through with the last one.
//   Reset clears the sequencer, the prime count and the result register.
//   When the receiver stalls, a result waits in the output register; the
//   block keeps taking and testing the next item and holds only when a
//   second result is ready before the first one has been taken.
// ----------------------------------------------------------------------------
module prime_filter_trial_division_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ptd_pkg::VALUE_W-1:0] in_tdata,  // [15:0] value
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,   // [15:0] prime_value, [23:16] prime_count
  output logic                      out_tuser,   // [0] keep
  output logic                      out_tlast    // run_end
);
  import ptd_pkg::*;

  state_t              state_r, state_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [VB-1:0]       val_r, val_nxt;
  logic                last_r, last_nxt;
  logic                prime_r, prime_nxt;
  logic [DIV_BITS-1:0] dvs_r, dvs_nxt;
  logic [SQ_BITS-1:0]  sq_r, sq_nxt;

  logic [VB-1:0]       in_val;
  logic                in_acc;
  logic                emit;
  logic                slot_free;
  logic                load;
  logic [COUNT_W-1:0]  count_upd;
  rem_req_t            rem_req;
  rem_rsp_t            rem_rsp;
  out_item_t           res;

  assign in_val    = in_tdata[VB-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Result assembly for the item in hand.
  assign emit      = prime_r || last_r;
  assign load      = (state_r == S_DONE) && emit && slot_free;
  assign count_upd = (prime_r && (count_r < MAX_LEN)) ? count_r + COUNT_W'(1) : count_r;

  assign res.prime_value = prime_r ? VALUE_W'(val_r) : '0;
  assign res.keep        = prime_r;
  assign res.prime_count = count_upd;
  assign res.run_end     = last_r;

  // Divider request: issued from the check state.
  assign rem_req.start    = (state_r == S_CHECK) && (sq_r <= SQ_BITS'(val_r));
  assign rem_req.dividend = val_r;
  assign rem_req.divisor  = dvs_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    prime_nxt = prime_r;
    dvs_nxt   = dvs_r;
    sq_nxt    = sq_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          val_nxt   = in_val;
          last_nxt  = in_tlast;
          dvs_nxt   = DIV_BITS'(3);
          sq_nxt    = SQ_BITS'(9);
          state_nxt = S_DONE;
          if (in_val < VB'(2)) begin
            prime_nxt = 1'b0;
          end else if ((in_val >> 2) == '0) begin
            prime_nxt = 1'b1;
          end else if (!in_val[0]) begin
            prime_nxt = 1'b0;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // Past the square root with no divisor found: prime.
        if (sq_r > SQ_BITS'(val_r)) begin
          prime_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_rsp.done) begin
          if (rem_rsp.zero) begin
            prime_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            // (d + 2)^2 = d^2 + 4d + 4
            dvs_nxt   = dvs_r + DIV_BITS'(2);
            sq_nxt    = sq_r + SQ_BITS'({dvs_r, 2'b00}) + SQ_BITS'(4);
            state_nxt = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (!emit) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          count_nxt = last_r ? '0 : count_upd;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Item payload and trial divisor.
  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    last_r  <= last_nxt;
    prime_r <= prime_nxt;
    dvs_r   <= dvs_nxt;
    sq_r    <= sq_nxt;
  end

  ptd_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  ptd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .item       (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // The prime count never passes its saturation point.
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_LEN)
    else $error("prime count above saturation point");

  // A result carrying the run end leaves the count cleared.
  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_r) |=> (count_r == '0))
    else $error("count not cleared after end of run");

  // The remainder unit is only started while idle.
  a_rem_start: assert property (@(posedge clk) disable iff (!rst_n)
    rem_req.start |-> !rem_rsp.busy)
    else $error("remainder unit started while busy");

  // A completed division is only reported while the sequencer waits for it.
  a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> (state_r == S_DIV))
    else $error("division finished outside the wait state");
`endif

endmodule
